/* design/bbb_pkg.sv */
// Shared types and constants of the bipartite byte buffer.
package bbb_pkg;

  // Field widths of the command and response words.
  localparam int CMD_W    = 2;
  localparam int LEN_W    = 13;
  localparam int DATA_W   = 64;
  localparam int STORED_W = 13;
  localparam int BYTE_W   = 8;
  localparam int LANE_W   = 3;

  typedef logic [CMD_W-1:0] cmd_t;

  // Command codes.
  localparam cmd_t CMD_WRITE  = 2'd0;
  localparam cmd_t CMD_READ   = 2'd1;
  localparam cmd_t CMD_PEEK   = 2'd2;
  localparam cmd_t CMD_REMOVE = 2'd3;

  // Decisions that the planning unit hands to the sequencer.
  typedef struct packed {
    logic len_ok;   // length within the chunk limit
    logic to_b;     // a write goes to region B
    logic wr_fits;  // a write has room
    logic rd_fits;  // enough bytes stored for the length
    logic move;     // folding B into A needs a byte copy
  } plan_flags_t;

endpackage

/* design/bbb_plan.sv */
// Planning unit: write placement, space checks and the fold of region B into A.
module bbb_plan #(
  parameter int BUFFER_BYTES = 4096,
  parameter int CHUNK_BYTES  = 8,
  parameter int AW           = 12,
  parameter int SW           = 13
) (
  input  bbb_pkg::cmd_t               cmd,
  input  logic [bbb_pkg::LEN_W-1:0]   length,
  input  logic [AW-1:0]               a_start,
  input  logic [SW-1:0]               a_size,
  input  logic                        b_open,
  input  logic [AW-1:0]               b_size,
  input  logic [SW-1:0]               drop,
  output bbb_pkg::plan_flags_t        flags,
  output logic [AW-1:0]               wr_base,
  output logic [SW-1:0]               drop_req,
  output logic [SW-1:0]               stored,
  output logic [AW-1:0]               fold_a_start,
  output logic [SW-1:0]               fold_a_size,
  output logic [AW-1:0]               fold_b_size,
  output logic                        fold_b_open,
  output logic [AW-1:0]               move_src
);
  import bbb_pkg::*;

  localparam int CW = (SW > LEN_W) ? SW : LEN_W;
  localparam logic [SW-1:0] BUF_SZ = SW'(BUFFER_BYTES);
  localparam logic [LEN_W-1:0] CHUNK_MAX = LEN_W'(CHUNK_BYTES);

  logic [SW-1:0] a_end;
  logic [SW-1:0] a_free;
  logic [SW-1:0] room;
  logic          to_b;
  logic          rd_fits;
  logic          a_cover;
  logic [SW-1:0] take_a;
  logic [SW-1:0] rest;
  logic [AW-1:0] take_b;
  logic [SW-1:0] new_a;
  logic [AW-1:0] new_b;

  // Space checks for the command word.
  always_comb begin
    stored  = a_size + SW'(b_size);
    a_end   = SW'(a_start) + a_size;
    a_free  = BUF_SZ - a_end;
    to_b    = b_open | (a_free < SW'(a_start));
    room    = to_b ? (SW'(a_start) - SW'(b_size)) : a_free;
    rd_fits = CW'(length) <= CW'(stored);
    wr_base = to_b ? b_size : AW'(a_end);
    // A remove is clamped to the stored bytes; a read drops its own length.
    drop_req = ((cmd == CMD_REMOVE) && !rd_fits) ? stored : SW'(length);
  end

  // Drop bytes from A, then from B; an emptied A takes over what is left of B.
  always_comb begin
    a_cover = drop >= a_size;
    take_a  = a_cover ? a_size : drop;
    rest    = a_cover ? (drop - a_size) : '0;
    take_b  = (rest >= SW'(b_size)) ? b_size : AW'(rest);
    new_a   = a_size - take_a;
    new_b   = b_size - take_b;
    if (new_a == '0) begin
      fold_a_start = '0;
      fold_a_size  = SW'(new_b);
      fold_b_size  = '0;
      fold_b_open  = 1'b0;
    end else begin
      fold_a_start = AW'(SW'(a_start) + take_a);
      fold_a_size  = new_a;
      fold_b_size  = b_size;
      fold_b_open  = b_open;
    end
    move_src = take_b;
  end

  assign flags.len_ok  = length <= CHUNK_MAX;
  assign flags.to_b    = to_b;
  assign flags.wr_fits = CW'(length) <= CW'(room);
  assign flags.rd_fits = rd_fits;
  assign flags.move    = (new_a == '0) && (new_b != '0) && (take_b != '0);

endmodule

/* design/bipartite_byte_buffer_top.sv */
// Top level of the bipartite byte buffer: sequencer, byte memory and response register.
//
// Each command word is handled one byte per cycle through a single byte memory with one
// write port and one registered read port. A command passes a decision step, then its
// byte steps (write or gather), a fold step for reads and removes, an optional copy and
// the response step. Refused commands and zero-length reads or peeks move no bytes.
// When region A empties while region B still holds bytes that do not start at the
// store's first byte, those bytes are copied down one per cycle. A new word is taken
// while an earlier response still waits for rsp_ready, and a finished word waits for
// that response to leave. After reset the block is ready at once; the memory needs no
// clearing, since only written bytes are ever read.
module bipartite_byte_buffer_top #(
  parameter int BUFFER_BYTES = 4096,
  parameter int CHUNK_BYTES  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  bbb_pkg::cmd_t                  cmd,
  input  logic [bbb_pkg::LEN_W-1:0]      length,
  input  logic [bbb_pkg::DATA_W-1:0]     write_data,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           ok,
  output logic [bbb_pkg::DATA_W-1:0]     read_data,
  output logic [bbb_pkg::STORED_W-1:0]   stored_bytes
);
  import bbb_pkg::*;

  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int SW    = AW + 1;
  localparam int CNT_W = $clog2(CHUNK_BYTES + 1);
  localparam logic [SW-1:0] BUF_SZ = SW'(BUFFER_BYTES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_GATHER = 3'd3;
  localparam logic [2:0] S_FOLD   = 3'd4;
  localparam logic [2:0] S_MOVE   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state;
  cmd_t              cmd_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] data_q;
  logic [CNT_W-1:0]  cnt_len;
  logic [CNT_W-1:0]  k;
  logic              pend;
  logic [LANE_W-1:0] pend_pos;
  logic              ok_q;
  logic [DATA_W-1:0] rd_q;
  logic [SW-1:0]     drop_q;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     src;
  logic [AW-1:0]     left;

  // Region state.
  logic [AW-1:0]     a_start;
  logic [SW-1:0]     a_size;
  logic              b_open;
  logic [AW-1:0]     b_size;

  // Planning unit outputs.
  plan_flags_t       flags;
  logic [AW-1:0]     wr_base;
  logic [SW-1:0]     drop_req;
  logic [SW-1:0]     stored;
  logic [AW-1:0]     fold_a_start;
  logic [SW-1:0]     fold_a_size;
  logic [AW-1:0]     fold_b_size;
  logic              fold_b_open;
  logic [AW-1:0]     move_src;

  // Byte memory ports.
  logic [BYTE_W-1:0] mem [BUFFER_BYTES];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_q;
  logic [SW-1:0]     k_ext;
  logic [AW-1:0]     gidx;

  bbb_plan #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .CHUNK_BYTES  (CHUNK_BYTES),
    .AW           (AW),
    .SW           (SW)
  ) u_plan (
    .cmd          (cmd_q),
    .length       (len_q),
    .a_start      (a_start),
    .a_size       (a_size),
    .b_open       (b_open),
    .b_size       (b_size),
    .drop         (drop_q),
    .flags        (flags),
    .wr_base      (wr_base),
    .drop_req     (drop_req),
    .stored       (stored),
    .fold_a_start (fold_a_start),
    .fold_a_size  (fold_a_size),
    .fold_b_size  (fold_b_size),
    .fold_b_open  (fold_b_open),
    .move_src     (move_src)
  );

  assign cmd_ready = (state == S_IDLE);

  // Logical byte k of the content lies in A first, then in B from the store's start.
  always_comb begin
    k_ext = SW'(k);
    gidx  = (k_ext < a_size) ? AW'(SW'(a_start) + k_ext) : AW'(k_ext - a_size);
  end

  // Memory port control for each state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = data_q[BYTE_W-1:0];
    mem_re    = 1'b0;
    mem_raddr = src;
    unique case (state)
      S_WRITE: begin
        mem_we = (k != cnt_len);
      end
      S_GATHER: begin
        mem_re    = (k != cnt_len);
        mem_raddr = gidx;
      end
      S_MOVE: begin
        mem_we    = pend;
        mem_wdata = mem_q;
        mem_re    = (left != '0);
      end
      default: begin
      end
    endcase
  end

  // Byte memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Sequencer and region bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      a_start   <= '0;
      a_size    <= '0;
      b_open    <= 1'b0;
      b_size    <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // A taken response clears here unless the next one is loaded below.
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q  <= cmd;
            len_q  <= length;
            data_q <= write_data;
            state  <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          rd_q    <= '0;
          k       <= '0;
          pend    <= 1'b0;
          cnt_len <= CNT_W'(len_q);
          drop_q  <= drop_req;
          unique case (cmd_q) inside
            CMD_WRITE: begin
              ok_q <= flags.len_ok && flags.wr_fits;
              if (flags.len_ok) begin
                b_open <= flags.to_b;
              end
              if (flags.len_ok && flags.wr_fits) begin
                ptr   <= wr_base;
                state <= S_WRITE;
                if (flags.to_b) begin
                  b_size <= b_size + AW'(len_q);
                end else begin
                  a_size <= a_size + SW'(len_q);
                end
              end else begin
                state <= S_DONE;
              end
            end
            CMD_READ, CMD_PEEK: begin
              ok_q  <= flags.len_ok && flags.rd_fits;
              state <= (flags.len_ok && flags.rd_fits) ? S_GATHER : S_DONE;
            end
            CMD_REMOVE: begin
              ok_q  <= 1'b1;
              state <= S_FOLD;
            end
          endcase
        end

        // One byte of the write word per cycle.
        S_WRITE: begin
          if (k != cnt_len) begin
            data_q <= data_q >> BYTE_W;
            ptr    <= ptr + AW'(1);
            k      <= k + CNT_W'(1);
          end else begin
            state <= S_DONE;
          end
        end

        // Read addresses go out one per cycle; each byte returns in the cycle after its address.
        S_GATHER: begin
          if (k != cnt_len) begin
            k <= k + CNT_W'(1);
          end
          pend     <= (k != cnt_len);
          pend_pos <= LANE_W'(k);
          if (pend) begin
            rd_q[{pend_pos, 3'b000} +: BYTE_W] <= mem_q;
          end
          if ((k == cnt_len) && !pend) begin
            state <= (cmd_q == CMD_READ) ? S_FOLD : S_DONE;
          end
        end

        // Apply the drop and start a copy if B must slide down.
        S_FOLD: begin
          a_start <= fold_a_start;
          a_size  <= fold_a_size;
          b_size  <= fold_b_size;
          b_open  <= fold_b_open;
          pend    <= 1'b0;
          if (flags.move) begin
            src   <= move_src;
            ptr   <= '0;
            left  <= AW'(fold_a_size);
            state <= S_MOVE;
          end else begin
            state <= S_DONE;
          end
        end

        // Copy toward the store's start: read at src, write in the next cycle at ptr.
        S_MOVE: begin
          if (left != '0) begin
            src  <= src + AW'(1);
            left <= left - AW'(1);
          end
          pend <= (left != '0);
          if (pend) begin
            ptr <= ptr + AW'(1);
          end
          if ((left == '0) && !pend) begin
            state <= S_DONE;
          end
        end

        // Load the response register once it is free.
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            ok           <= ok_q;
            read_data    <= rd_q;
            stored_bytes <= STORED_W'(stored);
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Region B never reaches into region A.
  b_below_a: assert property (@(posedge clk) disable iff (rst) b_size <= a_start)
    else $error("region B overlaps region A");

  // Region A never runs past the end of the store.
  a_in_store: assert property (@(posedge clk) disable iff (rst)
    (SW'(a_start) + a_size) <= BUF_SZ)
    else $error("region A runs past the end of the store");

  // An empty region A means the buffer is folded back to its start with B closed.
  empty_is_folded: assert property (@(posedge clk) disable iff (rst)
    (a_size == '0) |-> ((a_start == '0) && (b_size == '0) && !b_open))
    else $error("region A empty while region B still in use");

endmodule
